// ----- rtl/spf_pkg.sv -----
package spf_pkg;

   // Frame geometry.
   localparam int BYTE_W    = 8;
   localparam int FRAME_LEN = 12;
   localparam int IDX_W     = 4;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

   // CRC-8, polynomial x^8+x^5+x^4+1, MSB first, zero start value.
   localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
   localparam logic [BYTE_W-1:0] CRC_INIT = 8'h00;

   // One record as it travels on the input tdata: sensor_id in the lowest bits.
   typedef struct packed {
      logic [31:0] sample_value;
      logic [15:0] time_stamp;
      logic [7:0]  measure_kind;
      logic [31:0] sensor_id;
   } record_type;

   localparam int REC_W = $bits(record_type);

   // Advance the CRC over one byte, most significant bit first.
   function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                     input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] c;
      logic              flip;
      c = crc;
      for (int b = BYTE_W - 1; b >= 0; b--) begin
         flip = data[b] ^ c[BYTE_W-1];
         c    = {c[BYTE_W-2:0], 1'b0};
         if (flip) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

endpackage

// ----- rtl/sensor_packet_framer_crc8.sv -----
// A record accepted into an idle framer goes to the one-entry buffer, then to the
// serializer's shifter; its twelve bytes leave through the one-byte-wide output
// register on rsp_tdata at one per cycle while rsp_tready is high. The buffer holds
// the next record, so one record is accepted while a frame goes out and req_tready
// then stays low until the serializer takes it.
// Reset (synchronous, active high) empties the buffer and the output and drops
// any frame in progress; no clearing pass is needed.
module sensor_packet_framer_crc8
   import spf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // req_tdata, from bit 0: sensor_id[31:0], measure_kind[39:32],
   // time_stamp[55:40], sample_value[87:56]
   input  logic [REC_W-1:0]  req_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // rsp_tdata, from bit 0: frame_byte[7:0]
   output logic [BYTE_W-1:0] rsp_tdata,
   // rsp_tlast: frame_end
   output logic              rsp_tlast
);

   logic       pend_valid_ff, pend_valid_in;
   record_type pend_ff, pend_in;
   logic       rec_take;
   logic       req_beat;

   assign req_tready = !pend_valid_ff;
   assign req_beat   = req_tvalid && req_tready;

   // One-entry record buffer ahead of the serializer.
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      if (rec_take) begin
         pend_valid_in = 1'b0;
      end
      if (req_beat) begin
         pend_valid_in = 1'b1;
         pend_in       = record_type'(req_tdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
      end
      pend_ff <= pend_in;
   end

   spf_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .rec_valid  (pend_valid_ff),
      .rec        (pend_ff),
      .rec_take   (rec_take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // A record is only handed on from a full buffer.
   assert property (@(posedge clock) disable iff (reset)
      rec_take |-> pend_valid_ff)
      else $error("serializer took a record from an empty buffer");

   // An accepted beat is held in the buffer on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_beat |=> pend_valid_ff)
      else $error("accepted record lost from the buffer");

   // The buffer is neither refilled nor emptied without a handshake.
   assert property (@(posedge clock) disable iff (reset)
      (pend_valid_ff && !rec_take) |=> (pend_valid_ff && $stable(pend_ff)))
      else $error("buffered record changed while waiting");

endmodule

// ----- rtl/spf_serializer.sv -----
module spf_serializer
   import spf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              rec_valid,
   input  record_type        rec,
   output logic              rec_take,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [BYTE_W-1:0] rsp_tdata,
   output logic              rsp_tlast
);

   logic              active_ff, active_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [REC_W-1:0]  shift_ff, shift_in;
   logic [BYTE_W-1:0] crc_ff, crc_in;
   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_data_ff, out_data_in;
   logic              out_last_ff, out_last_in;
   logic [BYTE_W-1:0] cur_byte;
   logic              out_load;
   logic              last_beat;

   // The byte in flight: record bytes from the top of the shifter, then the CRC.
   assign cur_byte  = (idx_ff == LAST_IDX) ? crc_ff : shift_ff[REC_W-1 -: BYTE_W];
   assign out_load  = active_ff && (!out_valid_ff || rsp_tready);
   assign last_beat = out_load && (idx_ff == LAST_IDX);
   assign rec_take  = rec_valid && (!active_ff || last_beat);

   // Shifter and running CRC.
   always_comb begin
      active_in = active_ff;
      idx_in    = idx_ff;
      shift_in  = shift_ff;
      crc_in    = crc_ff;
      if (out_load) begin
         shift_in = {shift_ff[REC_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
         crc_in   = crc8_update(crc_ff, cur_byte);
         idx_in   = idx_ff + IDX_W'(1);
         if (last_beat) begin
            active_in = 1'b0;
         end
      end
      if (rec_take) begin
         active_in = 1'b1;
         idx_in    = '0;
         crc_in    = CRC_INIT;
         shift_in  = {rec.sensor_id, rec.measure_kind, rec.time_stamp, rec.sample_value};
      end
   end

   // Output register: a new beat loads when the slot is empty or being taken.
   always_comb begin
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      if (out_load) begin
         out_valid_in = 1'b1;
         out_data_in  = cur_byte;
         out_last_in  = (idx_ff == LAST_IDX);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
      shift_ff    <= shift_in;
      crc_ff      <= crc_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

   // A frame never runs past its CRC byte.
   assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (idx_ff <= LAST_IDX))
      else $error("frame byte index past the CRC byte");

   // A newly loaded record starts at its first byte with a cleared CRC.
   assert property (@(posedge clock) disable iff (reset)
      rec_take |=> (active_ff && idx_ff == '0 && crc_ff == CRC_INIT))
      else $error("record load did not restart the frame");

   // The CRC byte carries the end-of-frame mark, and only it does.
   assert property (@(posedge clock) disable iff (reset)
      out_load |=> (out_last_ff == ($past(idx_ff) == LAST_IDX)))
      else $error("end-of-frame mark on the wrong byte");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import spf_pkg::*;

   // One expected frame byte as it should leave the framer.
   typedef struct {
      logic [7:0] frame_byte;
      logic       frame_end;
   } frame_beat_type;

   // One record waiting to be sent; the hold flag keeps it back until the
   // framer has delivered everything it owes.
   typedef struct {
      record_type rec;
      bit         hold_for_drain;
   } pending_record_type;

   localparam logic [7:0] GEN_POLY = 8'h31;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REC_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [7:0]       rsp_tdata;
   logic             rsp_tlast;

   pending_record_type pending_records[$];
   frame_beat_type     expected_beats[$];

   logic req_taken = 1'b0;
   int   cycle_count = 0;
   int   records_sent = 0;
   int   beats_checked = 0;
   int   frames_ended = 0;
   int   failures = 0;
   int   mismatches = 0;
   bit   steady;

   sensor_packet_framer_crc8 dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // Free-running clock.
   initial begin
      forever #5 clock = ~clock;
   end

   // Both sides run without gaps during one window of the run.
   assign steady = (cycle_count >= 400) && (cycle_count < 900);

   // Serialize a record big-endian, field by field, and append the CRC-8.
   function automatic void queue_frame(input record_type rec);
      logic [7:0]     frame[12];
      logic [7:0]     crc;
      frame_beat_type beat;
      frame[0]  = rec.sensor_id[31:24];
      frame[1]  = rec.sensor_id[23:16];
      frame[2]  = rec.sensor_id[15:8];
      frame[3]  = rec.sensor_id[7:0];
      frame[4]  = rec.measure_kind;
      frame[5]  = rec.time_stamp[15:8];
      frame[6]  = rec.time_stamp[7:0];
      frame[7]  = rec.sample_value[31:24];
      frame[8]  = rec.sample_value[23:16];
      frame[9]  = rec.sample_value[15:8];
      frame[10] = rec.sample_value[7:0];
      // Byte-wise form: fold the byte in, then shift out eight bits.
      crc = 8'h00;
      for (int k = 0; k < 11; k++) begin
         crc = crc ^ frame[k];
         for (int b = 0; b < 8; b++) begin
            crc = crc[7] ? ((crc << 1) ^ GEN_POLY) : (crc << 1);
         end
      end
      frame[11] = crc;
      for (int k = 0; k < 12; k++) begin
         beat.frame_byte = frame[k];
         beat.frame_end  = (k == 11);
         expected_beats.push_back(beat);
      end
   endfunction

   function automatic void add_record(input logic [31:0] id, input logic [7:0] kind,
                                      input logic [15:0] stamp, input logic [31:0] value,
                                      input bit hold);
      pending_record_type p;
      p.rec.sensor_id    = id;
      p.rec.measure_kind = kind;
      p.rec.time_stamp   = stamp;
      p.rec.sample_value = value;
      p.hold_for_drain   = hold;
      pending_records.push_back(p);
   endfunction

   // A field is mostly random, sometimes pinned to one of its extremes.
   function automatic logic [31:0] pick_field(input logic [31:0] top);
      int roll;
      roll = $urandom_range(15);
      if (roll == 0) begin
         return 32'd0;
      end else if (roll == 1) begin
         return top;
      end
      return $urandom() & top;
   endfunction

   // Driver: inputs change on the falling edge.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (pending_records.size() > 0 &&
             !(pending_records[0].hold_for_drain && expected_beats.size() > 0) &&
             (steady || $urandom_range(99) >= 34)) begin
            req_tdata  <= pending_records[0].rec;
            req_tvalid <= 1'b1;
            void'(pending_records.pop_front());
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= steady || ($urandom_range(99) >= 34);
   end

   // Monitor: record accepted records and check frame beats on the rising edge.
   always @(posedge clock) begin
      frame_beat_type want;
      cycle_count <= cycle_count + 1;
      req_taken   <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         queue_frame(record_type'(req_tdata));
         records_sent <= records_sent + 1;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_beats.size() == 0) begin
            failures++;
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected beat: tdata=%02h tlast=%b", rsp_tdata, rsp_tlast);
            end
         end else begin
            want = expected_beats.pop_front();
            beats_checked <= beats_checked + 1;
            if (rsp_tlast === 1'b1) begin
               frames_ended <= frames_ended + 1;
            end
            if (rsp_tdata !== want.frame_byte || rsp_tlast !== want.frame_end) begin
               failures++;
               mismatches++;
               if (mismatches <= 10) begin
                  $display("beat mismatch: expected tdata=%02h tlast=%b, got tdata=%02h tlast=%b",
                           want.frame_byte, want.frame_end, rsp_tdata, rsp_tlast);
               end
            end
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      bit hold;

      // Directed records: extremes, single bits and patterns in every field.
      add_record(32'h0000_0000, 8'h00, 16'h0000, 32'h0000_0000, 1'b0);
      add_record(32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
      add_record(32'h8000_0000, 8'h00, 16'h0000, 32'h0000_0000, 1'b0);
      add_record(32'h0000_0001, 8'h80, 16'h0000, 32'h0000_0000, 1'b0);
      add_record(32'h0000_0000, 8'h01, 16'h8000, 32'h0000_0000, 1'b0);
      add_record(32'h0000_0000, 8'h00, 16'h0001, 32'h8000_0000, 1'b0);
      add_record(32'h0000_0000, 8'h00, 16'h0000, 32'h0000_0001, 1'b0);
      add_record(32'hAAAA_AAAA, 8'hAA, 16'hAAAA, 32'hAAAA_AAAA, 1'b0);
      add_record(32'h5555_5555, 8'h55, 16'h5555, 32'h5555_5555, 1'b0);
      add_record(32'h0123_4567, 8'h89, 16'hABCD, 32'hEF01_2345, 1'b0);
      add_record(32'hFFFF_FFFF, 8'h00, 16'hFFFF, 32'h0000_0000, 1'b0);
      add_record(32'h0000_0000, 8'hFF, 16'h0000, 32'hFFFF_FFFF, 1'b0);
      add_record(32'h3131_3131, 8'h31, 16'h3131, 32'h3131_3131, 1'b0);

      // Random records; twice the sender holds back until the framer drains.
      for (int i = 0; i < 100; i++) begin
         hold = (i == 0) || (i == 60);
         add_record(pick_field(32'hFFFF_FFFF), pick_field(32'h0000_00FF),
                    pick_field(32'h0000_FFFF), pick_field(32'hFFFF_FFFF), hold);
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (pending_records.size() == 0 && !req_tvalid);
      wait (expected_beats.size() == 0);
      repeat (20) @(posedge clock);
      if (expected_beats.size() != 0 || rsp_tvalid === 1'b1) begin
         failures++;
         $display("framer still busy after the last expected beat");
      end

      $display("Sent %0d records (directed extremes and patterns, then random).",
               records_sent);
      $display("Checked %0d frame beats across %0d completed frames, %0d mismatches.",
               beats_checked, frames_ended, mismatches);
      if (failures == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #2_000_000;
      $display("timeout waiting for the framer");
      $display("FAIL");
      $finish;
   end

endmodule

// ----- sensor_packet_framer_crc8.f -----
rtl/spf_pkg.sv
rtl/spf_serializer.sv
rtl/sensor_packet_framer_crc8.sv
tb/sv/tb.sv
